// ===== src/rtalu_pkg.sv =====
// Shared types for the R-type ALU with register file: command codes and the
// packed transfer types of the instruction and result channels.
// No dependencies.
package rtalu_pkg;

  typedef enum logic [3:0] {
    CmdAdd  = 4'd0,
    CmdSub  = 4'd1,
    CmdAnd  = 4'd2,
    CmdOr   = 4'd3,
    CmdXor  = 4'd4,
    CmdNor  = 4'd5,
    CmdNand = 4'd6,
    CmdSlt  = 4'd7,
    CmdSll  = 4'd8,
    CmdSrl  = 4'd9,
    CmdSra  = 4'd10,
    CmdJr   = 4'd11,
    CmdLoad = 4'd12
  } cmd_e;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned IdxWidth  = 5;

  typedef struct packed {
    logic [3:0]           command;
    logic [IdxWidth-1:0]  source_index;
    logic [IdxWidth-1:0]  second_index;
    logic [IdxWidth-1:0]  dest_index;
    logic [IdxWidth-1:0]  shift_amount;
    logic [WordWidth-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [WordWidth-1:0] written_value;
    logic                 jump_taken;
    logic [WordWidth-1:0] jump_target;
  } out_item_t;

endpackage

// ===== src/rtalu_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; contents are undefined until written.
module rtalu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/r_type_alu_with_register_file.sv =====
// Top level of the R-type ALU: register file in two mirrored RAMs, the
// execute stage and the result register. Uses rtalu_pkg and rtalu_ram.
//
//   Channel   Direction  Handshake               Transfer type
//   in        input      in_valid_i / in_stall_o  in_item_t (one instruction)
//   out       output     out_valid_o/out_stall_i  out_item_t (one result)
//
// An instruction transfer starts the register reads of rs and rt in the two
// RAM copies. While the instruction sits in the execute stage the read data,
// forwarded from the write done at the edge of the read where needed, feed the
// ALU, and the result is written back and loaded into the output register.
// The instruction passes the execute register and then the output register, and
// one instruction per cycle is sustained while the output is not stalled.
// Reset clears the per-register valid bits, so every register reads as zero
// after reset without a clearing pass. A stall on the output holds the
// execute stage, which in turn stalls the input.
module r_type_alu_with_register_file
  import rtalu_pkg::*;
#(
  parameter int NUM_REGS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Handshake and stage control.
  logic      in_accept;
  logic      s1_adv;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_q;

  // Register file: two RAM copies give two read ports; a valid bit per
  // register stands for the all-zero reset contents.
  logic [NUM_REGS-1:0]  valid_q;
  logic [WordWidth-1:0] ram_a;
  logic [WordWidth-1:0] ram_b;

  // The last write, kept to forward into the read that was taken at the same
  // edge (the RAM returns the old word in that case).
  logic                 wr_en_q;
  logic [AW-1:0]        wr_addr_q;
  logic [WordWidth-1:0] wr_data_q;

  logic                 wr_en_d;
  logic [AW-1:0]        wr_addr_d;

  logic [AW-1:0]        rs_addr;
  logic [AW-1:0]        rt_addr;
  logic                 rs_ok;
  logic                 rt_ok;
  logic                 rd_ok;
  logic                 fwd_a;
  logic                 fwd_b;
  logic [WordWidth-1:0] op_a;
  logic [WordWidth-1:0] op_b;
  logic [WordWidth-1:0] res;
  logic                 writes;
  logic                 jump;
  cmd_e                 cmd;
  out_item_t            result;

  // The execute stage moves on whenever the output register is free or
  // being emptied in this cycle.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  rtalu_ram #(
    .Width (WordWidth),
    .Depth (NUM_REGS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en_d),
    .waddr_i (wr_addr_d),
    .wdata_i (res),
    .re_i    (in_accept),
    .raddr_i (AW'(in_data_i.source_index)),
    .rdata_o (ram_a)
  );

  rtalu_ram #(
    .Width (WordWidth),
    .Depth (NUM_REGS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en_d),
    .waddr_i (wr_addr_d),
    .wdata_i (res),
    .re_i    (in_accept),
    .raddr_i (AW'(in_data_i.second_index)),
    .rdata_o (ram_b)
  );

  // Register numbers at or beyond the file size read as zero and are never
  // written.
  assign rs_addr = AW'(s1_item_q.source_index);
  assign rt_addr = AW'(s1_item_q.second_index);
  assign rs_ok   = int'(s1_item_q.source_index) < NUM_REGS;
  assign rt_ok   = int'(s1_item_q.second_index) < NUM_REGS;
  assign rd_ok   = int'(s1_item_q.dest_index) < NUM_REGS;

  assign fwd_a = rs_ok && wr_en_q && (wr_addr_q == rs_addr);
  assign fwd_b = rt_ok && wr_en_q && (wr_addr_q == rt_addr);

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (fwd_a) begin
      op_a = wr_data_q;
    end else if (rs_ok && valid_q[rs_addr]) begin
      op_a = ram_a;
    end
    if (fwd_b) begin
      op_b = wr_data_q;
    end else if (rt_ok && valid_q[rt_addr]) begin
      op_b = ram_b;
    end
  end

  assign cmd = cmd_e'(s1_item_q.command);

  always_comb begin
    res    = '0;
    writes = 1'b1;
    jump   = 1'b0;
    case (cmd)
      CmdAdd:  res = op_a + op_b;
      CmdSub:  res = op_a - op_b;
      CmdAnd:  res = op_a & op_b;
      CmdOr:   res = op_a | op_b;
      CmdXor:  res = op_a ^ op_b;
      CmdNor:  res = ~(op_a | op_b);
      CmdNand: res = ~(op_a & op_b);
      CmdSlt:  res = {{(WordWidth-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
      CmdSll:  res = op_b << s1_item_q.shift_amount;
      CmdSrl:  res = op_b >> s1_item_q.shift_amount;
      CmdSra:  res = $unsigned($signed(op_b) >>> s1_item_q.shift_amount);
      CmdJr: begin
        writes = 1'b0;
        jump   = 1'b1;
      end
      CmdLoad: res = s1_item_q.load_value;
      default: writes = 1'b0;
    endcase
  end

  assign wr_en_d   = s1_adv && writes && rd_ok;
  assign wr_addr_d = AW'(s1_item_q.dest_index);

  always_comb begin
    result.written_value = res;
    result.jump_taken    = jump;
    result.jump_target   = jump ? op_a : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_en_q     <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        wr_en_q <= wr_en_d;
      end
      if (wr_en_d) begin
        valid_q[wr_addr_d] <= 1'b1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q     <= result;
      wr_addr_q <= wr_addr_d;
      wr_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The input is held back only by an instruction waiting in execute.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty execute stage");

  // A register write leaves that register marked as written.
  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_d |=> (wr_en_q && valid_q[wr_addr_q]))
    else $error("written register not marked valid");

  // A new result appears only when execute hands one over.
  a_result_from_execute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("result appeared without an execute handover");

  // A jump result never reports a written word.
  a_jump_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.jump_taken) |-> (out_data_o.written_value == '0))
    else $error("jump result carries a written value");

  // Forwarding only ever hits a register that holds a written value.
  a_forward_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && fwd_a) |-> valid_q[rs_addr])
    else $error("forwarded from a register never written");
`endif

endmodule

// ===== sim/r_type_alu_with_register_file_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for r_type_alu_with_register_file. It needs only
// rtalu_pkg and the block. A shadow register file predicts every result, and
// the block's results are compared with those predictions in order.
module r_type_alu_with_register_file_tb;
  import rtalu_pkg::*;

  // Codes 13 to 15 are not assigned to any operation. The block must write
  // nothing for them and must report an all-zero result.
  localparam logic [3:0] CmdSpareFirst = 4'd13;
  localparam logic [3:0] CmdSpareLast  = 4'd15;

  localparam int unsigned RegCount     = 32;
  localparam int unsigned RandomItems  = 1300;
  localparam int unsigned RandomPhases = 4;
  localparam int unsigned MaxReports   = 20;
  localparam int unsigned DrainCycles  = 8;

  // The shadow register file mirrors the block's architectural state. Each
  // accepted instruction is executed here when the block accepts it. The
  // result that the block must later produce is queued.
  class regfile_alu_shadow;
    logic [WordWidth-1:0] regs [RegCount];
    out_item_t            pending_results [$];
    int unsigned          mismatch_count;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mismatch_count = 0;
    endfunction

    // An index past the end of the file reads as zero. With 32 registers
    // and 5-bit indexes this cannot happen, but the rule is kept anyway.
    function logic [WordWidth-1:0] read_reg(logic [IdxWidth-1:0] idx);
      return (idx < RegCount) ? regs[idx] : '0;
    endfunction

    function void note_instruction(in_item_t ins);
      logic [WordWidth-1:0] rs_val;
      logic [WordWidth-1:0] rt_val;
      logic [WordWidth-1:0] value;
      out_item_t            res;
      bit                   writes;
      rs_val = read_reg(ins.source_index);
      rt_val = read_reg(ins.second_index);
      value  = '0;
      res    = '0;
      writes = 1'b1;
      case (ins.command)
        CmdAdd:  value = rs_val + rt_val;
        CmdSub:  value = rs_val - rt_val;
        CmdAnd:  value = rs_val & rt_val;
        CmdOr:   value = rs_val | rt_val;
        CmdXor:  value = rs_val ^ rt_val;
        CmdNor:  value = ~(rs_val | rt_val);
        CmdNand: value = ~(rs_val & rt_val);
        CmdSlt:  value = ($signed(rs_val) < $signed(rt_val)) ? 32'd1 : 32'd0;
        CmdSll:  value = rt_val << ins.shift_amount;
        CmdSrl:  value = rt_val >> ins.shift_amount;
        CmdSra:  value = $signed(rt_val) >>> ins.shift_amount;
        CmdJr: begin
          // A jump reports rs as the target and leaves the file untouched.
          writes          = 1'b0;
          res.jump_taken  = 1'b1;
          res.jump_target = rs_val;
        end
        CmdLoad: value = ins.load_value;
        default: writes = 1'b0;
      endcase
      if (writes && ins.dest_index < RegCount) regs[ins.dest_index] = value;
      res.written_value = value;
      pending_results.push_back(res);
    endfunction

    function void report_field(string name, logic [WordWidth-1:0] want,
                               logic [WordWidth-1:0] got);
      if (want !== got) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: result expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      report_field("written_value", want.written_value, got.written_value);
      report_field("jump_taken", WordWidth'(want.jump_taken),
                   WordWidth'(got.jump_taken));
      report_field("jump_target", want.jump_target, got.jump_target);
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  // When this is set, neither the sender nor the receiver inserts idle cycles,
  // so the block is run at its full rate of one instruction per cycle.
  bit no_idle;

  regfile_alu_shadow shadow;

  r_type_alu_with_register_file dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Both channels are observed at the same edge. The instruction is noted
  // first, so even a result in the same cycle would find its prediction
  // waiting. All testbench drives after initialisation are nonblocking, so the
  // values seen here are the ones present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) shadow.note_instruction(in_data_i);
      if (out_valid_o && !out_stall_i) shadow.check_result(out_data_o);
    end
  end

  // Most gaps are short or absent. A few are long, so that stalls and bubbles
  // fall on every stage of the pipeline.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver side. Each free run waits on the clock before the stall is raised,
  // so the stall never gets two assignments in one time step.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      out_stall_i <= 1'b0;
      repeat (1 + pick_gap()) @(posedge clk_i);
      hold = pick_gap();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  function automatic in_item_t make_instr(logic [3:0] cmd, int unsigned rs,
                                          int unsigned rt, int unsigned rd,
                                          int unsigned sh,
                                          logic [WordWidth-1:0] lv);
    in_item_t ins;
    ins.command      = cmd;
    ins.source_index = IdxWidth'(rs);
    ins.second_index = IdxWidth'(rt);
    ins.dest_index   = IdxWidth'(rd);
    ins.shift_amount = IdxWidth'(sh);
    ins.load_value   = lv;
    return ins;
  endfunction

  // Loads come often enough to refresh the file with corner values, so that
  // the ALU keeps seeing the sign bit, all ones and zero as operands.
  function automatic in_item_t random_instruction();
    in_item_t    ins;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) ins.command = 4'($urandom_range(CmdSpareFirst, CmdSpareLast));
    else if (roll < 24) ins.command = CmdLoad;
    else ins.command = 4'($urandom_range(CmdAdd, CmdJr));
    ins.source_index = IdxWidth'($urandom());
    ins.second_index = IdxWidth'($urandom());
    ins.dest_index   = IdxWidth'($urandom());
    ins.shift_amount = IdxWidth'($urandom());
    case ($urandom_range(0, 9))
      0:       ins.load_value = 32'h0000_0000;
      1:       ins.load_value = 32'hFFFF_FFFF;
      2:       ins.load_value = 32'h8000_0000;
      3:       ins.load_value = 32'h7FFF_FFFF;
      4:       ins.load_value = 32'h0000_0001;
      default: ins.load_value = $urandom();
    endcase
    return ins;
  endfunction

  // Valid is lowered only when a gap is requested. Back-to-back transfers
  // therefore keep it high. The task returns at the edge of the transfer.
  task automatic send_instruction(in_item_t ins, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= ins;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The sender holds off until every predicted result has come back. The
  // first edge lets the observer record a transfer made at the current edge.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Directed opening. The corner values are loaded first, including register
  // 0, which is an ordinary register here. After that every operation is run
  // on them: wraparound in add and sub, signed compare across the sign
  // boundary, shifts by 0 and by 31, a jump that must not write, and the spare
  // codes. A final read shows that the jump and the first spare code wrote nothing.
  task automatic run_directed();
    send_instruction(make_instr(CmdLoad, 0, 0, 1, 0, 32'hFFFF_FFFF), 0);
    send_instruction(make_instr(CmdLoad, 31, 31, 2, 31, 32'h8000_0000), 0);
    send_instruction(make_instr(CmdLoad, 0, 0, 31, 0, 32'h7FFF_FFFF), 0);
    send_instruction(make_instr(CmdLoad, 0, 0, 0, 0, 32'h0000_0001), 0);
    send_instruction(make_instr(CmdAdd, 1, 0, 3, 0, '0), 0);
    send_instruction(make_instr(CmdSub, 2, 0, 4, 0, '0), 0);
    send_instruction(make_instr(CmdAnd, 1, 2, 5, 0, '0), 0);
    send_instruction(make_instr(CmdOr, 31, 2, 6, 0, '0), 0);
    send_instruction(make_instr(CmdXor, 1, 31, 7, 0, '0), 0);
    send_instruction(make_instr(CmdNor, 3, 3, 8, 0, '0), 0);
    send_instruction(make_instr(CmdNand, 1, 1, 9, 0, '0), 0);
    send_instruction(make_instr(CmdSlt, 2, 31, 10, 0, '0), 0);
    send_instruction(make_instr(CmdSlt, 31, 2, 11, 0, '0), 0);
    send_instruction(make_instr(CmdSlt, 1, 0, 12, 0, '0), 0);
    send_instruction(make_instr(CmdSll, 31, 1, 13, 31, '0), 0);
    send_instruction(make_instr(CmdSll, 2, 0, 14, 0, '0), 0);
    send_instruction(make_instr(CmdSrl, 0, 2, 15, 31, '0), 0);
    send_instruction(make_instr(CmdSra, 0, 2, 16, 31, '0), 0);
    send_instruction(make_instr(CmdSra, 0, 31, 17, 4, '0), 0);
    send_instruction(make_instr(CmdJr, 2, 1, 20, 0, 32'hFFFF_FFFF), 0);
    send_instruction(make_instr(CmdSpareFirst, 1, 1, 21, 0, 32'hFFFF_FFFF), 0);
    send_instruction(make_instr(CmdSpareLast, 1, 1, 22, 31, 32'hFFFF_FFFF), 0);
    send_instruction(make_instr(CmdOr, 20, 21, 23, 0, '0), 0);
    send_instruction(make_instr(CmdSra, 0, 1, 24, 0, '0), 0);
  endtask

  initial begin
    shadow     = new();
    no_idle    = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_for_results();

    // The first phase runs with no idle cycles on either side. The other
    // phases draw random gaps and stalls. Now and then the sender also waits
    // for the pipeline to empty completely.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      no_idle = (phase == 0);
      for (int unsigned n = 0; n < RandomItems / RandomPhases; n++) begin
        if ($urandom_range(0, 149) == 0) wait_for_results();
        send_instruction(random_instruction(), pick_gap());
      end
      wait_for_results();
    end

    // Allow a drain period of DrainCycles so that any extra result shows up as a failure.
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.mismatch_count == 0) begin
      $display("PASS r_type_alu_with_register_file");
    end else begin
      $display("FAIL r_type_alu_with_register_file");
    end
    $finish;
  end

  // The worst case is about 1300 transfers, each with the longest gap and the
  // longest stall, which is under 1 ms. The limit allows five times that.
  initial begin
    #5_000_000;
    $display("FAIL r_type_alu_with_register_file");
    $finish;
  end

endmodule
